/* rtl/core/pcm_to_s8_nearest_resampler_top_assert.svh */
// Assertion macros for the checker file.
`ifndef PCM_TO_S8_NEAREST_RESAMPLER_TOP_ASSERT_SVH
`define PCM_TO_S8_NEAREST_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define PS8R_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ps8r check failed");

// Next-cycle implication, off while reset is asserted.
`define PS8R_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ps8r check failed");

`endif

/* rtl/core/ps8r_pkg.sv */
package ps8r_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT   = 3'd0,
    CFG_CHANNELS = 3'd1,
    CFG_MIX      = 3'd2,
    CFG_SRC      = 3'd3,
    CFG_DEST     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FMT_U8     = 2'd0,
    FMT_S8     = 2'd1,
    FMT_S16_LE = 2'd2,
    FMT_S16_BE = 2'd3
  } fmt_e;

  localparam logic [1:0] CHAN_STEREO = 2'd2;
  localparam logic [7:0] SIGN_FLIP   = 8'h80;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic skip_dec;
    logic run_one;
    logic run_all;
    logic div_run_start;
    logic run_from_div;
    logic clamp;
    logic mul;
    logic add;
    logic fold_none;
    logic fold_one;
    logic div_acc_start;
    logic fold_div;
    logic emit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip_nz;
    logic finished;
    logic fast_run;
    logic src_zero;
    logic div_done;
    logic fold_none_ok;
    logic fold_one_ok;
    logic out_free;
    logic emit_last;
  } ctrl_sts_t;

endpackage

/* rtl/core/ps8r_div.sv */
// Restoring divider, one quotient bit per cycle.
// A short operation runs SHORT_STEPS steps on a numerator aligned to the top bits.
module ps8r_div #(
  parameter int NW          = 49,
  parameter int DW          = 24,
  parameter int SHORT_STEPS = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          short_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q, den_q;
  logic [DW:0]     trial, diff;
  logic            ge;
  logic [DW-1:0]   rem_d;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= short_i ? CNTW'(SHORT_STEPS) : CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/ps8r_dp.sv */
// Resampler datapath: config registers, timeline state, run arithmetic,
// sample decode and the output register.
module ps8r_dp #(
  parameter int COUNT_WIDTH = 24,
  parameter int MAX_RUN     = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ps8r_pkg::ctrl_cmd_t            cmd_i,
  output ps8r_pkg::ctrl_sts_t            sts_o,
  input  logic                           in_first_i,
  input  logic [31:0]                    in_data_i,
  input  logic                           cfg_valid_i,
  input  logic [ps8r_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ps8r_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [15:0]                    out_data_o,
  output logic                           out_last_o,
  output logic [2:0]                     out_user_o
);

  import ps8r_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int AW = CW + 1;
  localparam int NW = 2 * CW + 1;
  localparam int RW = $clog2(MAX_RUN + 1);

  // config
  logic [1:0]    fmt_q, chan_q;
  logic          mix_q;
  logic [CW-1:0] src_q, dest_q;

  // timeline
  logic [AW-1:0] acc_q;
  logic [CW-1:0] emitted_q, skip_q;

  // per-item work registers
  logic [3:0][7:0] bytes_q;
  logic [AW-1:0]   run_q;
  logic [CW-1:0]   actual_q;
  logic [RW-1:0]   shown_q;
  logic            trunc_q;
  logic [2*CW-1:0] prod_q;
  logic [NW-1:0]   accw_q;

  // output register
  logic       out_valid_q;
  logic [7:0] left_q, right_q;
  logic       stereo_q, last_q, otrunc_q, done_q;

  logic [CW-1:0]   remaining, actual;
  logic [CW+1:0]   acc_src, num1_full;
  logic [NW-1:0]   dest_w, fold_diff, div_num, quot, k_m1;
  logic [CW-1:0]   div_den, div_rem, skip_sat;
  logic            div_start, div_done, out_free, emit_last;
  logic [RW-1:0]   shown;
  logic            trunc;

  // decode
  logic [1:0]      idx_a, idx_b;
  logic [7:0]      flip, ch_a, ch_b, mix_s, left_d, right_d;
  logic [8:0]      pair_sum;
  logic            stereo_in, stereo_d;

  always_comb begin
    remaining = dest_q - emitted_q;
    acc_src   = (CW+2)'(acc_q) + (CW+2)'(src_q);
    num1_full = (CW+2)'(dest_q) - (CW+2)'(acc_q) + (CW+2)'(src_q) - (CW+2)'(1);
    actual    = (run_q < AW'(remaining)) ? run_q[CW-1:0] : remaining;
    shown     = (actual < CW'(MAX_RUN)) ? actual[RW-1:0] : RW'(MAX_RUN);
    trunc     = actual > CW'(MAX_RUN);
    dest_w    = NW'(dest_q);
    fold_diff = accw_q - dest_w;
    k_m1      = quot - NW'(1);
    skip_sat  = (|k_m1[NW-1:CW]) ? '1 : k_m1[CW-1:0];
    div_start = cmd_i.div_run_start | cmd_i.div_acc_start;
    div_num   = cmd_i.div_run_start ? {num1_full[AW-1:0], {CW{1'b0}}} : accw_q;
    div_den   = cmd_i.div_run_start ? src_q : dest_q;
    out_free  = !out_valid_q || out_ready_i;
    emit_last = shown_q == RW'(1);
  end

  always_comb begin
    sts_o              = '0;
    sts_o.skip_nz      = skip_q != '0;
    sts_o.finished     = emitted_q >= dest_q;
    sts_o.fast_run     = acc_src >= (CW+2)'(dest_q);
    sts_o.src_zero     = src_q == '0;
    sts_o.div_done     = div_done;
    sts_o.fold_none_ok = (dest_q == '0) || (accw_q < dest_w);
    sts_o.fold_one_ok  = fold_diff < dest_w;
    sts_o.out_free     = out_free;
    sts_o.emit_last    = emit_last;
  end

  // pick the top byte of each channel
  always_comb begin
    flip = 8'h00;
    case (fmt_q)
      FMT_U8: begin
        idx_a = 2'd0; idx_b = 2'd1; flip = SIGN_FLIP;
      end
      FMT_S8: begin
        idx_a = 2'd0; idx_b = 2'd1;
      end
      FMT_S16_LE: begin
        idx_a = 2'd1; idx_b = 2'd3;
      end
      FMT_S16_BE: begin
        idx_a = 2'd0; idx_b = 2'd2;
      end
      default: begin
        idx_a = 2'd0; idx_b = 2'd1;
      end
    endcase
    ch_a      = bytes_q[idx_a] ^ flip;
    ch_b      = bytes_q[idx_b] ^ flip;
    pair_sum  = {ch_a[7], ch_a} + {ch_b[7], ch_b};
    mix_s     = pair_sum[8:1];  // floor average
    stereo_in = chan_q == CHAN_STEREO;
    stereo_d  = stereo_in && !mix_q;
    left_d    = (stereo_in && mix_q) ? mix_s : ch_a;
    right_d   = stereo_d ? ch_b : 8'h00;
  end

  ps8r_div #(
    .NW          (NW),
    .DW          (CW),
    .SHORT_STEPS (AW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .short_i (cmd_i.div_run_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot),
    .rem_o   (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_U8;
      chan_q      <= 2'd1;
      mix_q       <= 1'b0;
      src_q       <= CW'(1);
      dest_q      <= CW'(1);
      acc_q       <= '0;
      emitted_q   <= '0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_FORMAT:   fmt_q  <= cfg_data_i[1:0];
          CFG_CHANNELS: chan_q <= cfg_data_i[1:0];
          CFG_MIX:      mix_q  <= cfg_data_i[0];
          CFG_SRC:      src_q  <= CW'(cfg_data_i);
          CFG_DEST:     dest_q <= CW'(cfg_data_i);
          default: ;
        endcase
      end
      if (cmd_i.load && in_first_i) begin
        acc_q     <= '0;
        emitted_q <= '0;
        skip_q    <= '0;
      end
      if (cmd_i.skip_dec) skip_q <= skip_q - CW'(1);
      if (cmd_i.clamp) emitted_q <= emitted_q + actual;
      if (cmd_i.fold_none) acc_q <= accw_q[AW-1:0];
      if (cmd_i.fold_one) begin
        acc_q  <= fold_diff[AW-1:0];
        skip_q <= '0;
      end
      if (cmd_i.fold_div) begin
        acc_q  <= AW'(div_rem);
        skip_q <= skip_sat;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) bytes_q <= in_data_i;
    if (cmd_i.run_one) run_q <= AW'(1);
    if (cmd_i.run_all) run_q <= AW'(remaining);
    if (cmd_i.run_from_div) run_q <= quot[AW-1:0];
    if (cmd_i.clamp) begin
      actual_q <= actual;
      shown_q  <= shown;
      trunc_q  <= trunc;
    end
    if (cmd_i.mul) prod_q <= actual_q * src_q;
    if (cmd_i.add) accw_q <= NW'(acc_q) + NW'(prod_q);
    if (cmd_i.emit) begin
      shown_q  <= shown_q - RW'(1);
      left_q   <= left_d;
      right_q  <= right_d;
      stereo_q <= stereo_d;
      last_q   <= emit_last;
      otrunc_q <= trunc_q;
      done_q   <= emit_last && (emitted_q >= dest_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {right_q, left_q};
  assign out_last_o  = last_q;
  assign out_user_o  = {done_q, otrunc_q, stereo_q};

endmodule

/* rtl/core/ps8r_ctrl.sv */
// Sequencer: one source frame at a time through eval and, unless it is
// skipped or late, run length, clamp, accumulate, fold and emit.
module ps8r_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ps8r_pkg::ctrl_sts_t sts_i,
  output ps8r_pkg::ctrl_cmd_t cmd_o
);

  import ps8r_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_RUN,
    ST_CLAMP,
    ST_MUL,
    ST_ADD,
    ST_FOLD,
    ST_DIV_ACC,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.skip_nz) begin
          cmd_o.skip_dec = 1'b1;
          state_d        = ST_IDLE;
        end else if (sts_i.finished) begin
          state_d = ST_IDLE;
        end else if (sts_i.fast_run) begin
          cmd_o.run_one = 1'b1;
          state_d       = ST_CLAMP;
        end else if (sts_i.src_zero) begin
          cmd_o.run_all = 1'b1;
          state_d       = ST_CLAMP;
        end else begin
          cmd_o.div_run_start = 1'b1;
          state_d             = ST_DIV_RUN;
        end
      end
      ST_DIV_RUN: begin
        if (sts_i.div_done) begin
          cmd_o.run_from_div = 1'b1;
          state_d            = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_FOLD;
      end
      ST_FOLD: begin
        if (sts_i.fold_none_ok) begin
          cmd_o.fold_none = 1'b1;
          state_d         = ST_EMIT;
        end else if (sts_i.fold_one_ok) begin
          cmd_o.fold_one = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.div_acc_start = 1'b1;
          state_d             = ST_DIV_ACC;
        end
      end
      ST_DIV_ACC: begin
        if (sts_i.div_done) begin
          cmd_o.fold_div = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_IDLE) cmd_o.load = in_valid_i & rdy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= state_d == ST_IDLE;
    end
  end

  assign in_ready_o = rdy_q;

endmodule

/* rtl/core/pcm_to_s8_nearest_resampler_top.sv */
// Channel   Dir   Handshake                      Payload
// s_axis    in    s_axis_tvalid / s_axis_tready  one source frame (4 raw bytes), first flag
// m_axis    out   m_axis_tvalid / m_axis_tready  one signed 8-bit destination frame
// cfg       in    cfg_valid_i / cfg_ready_o      register index and write data
//
// A source frame that is skipped or arrives after the conversion is finished
// passes through eval only. A frame that emits steps through eval, clamp,
// multiply, add, fold and one emit per emitted frame (at most MAX_RUN), with
// a serial divider pass before clamp when the run length needs one, and
// another after fold when the accumulator wraps more than once over dest_frames.
// Output stalls hold the emit loop; the last result may wait in the output
// register while the next frame is taken. Reset clears the timeline and loads
// the register defaults; config is taken in any cycle.
module pcm_to_s8_nearest_resampler_top #(
  parameter int COUNT_WIDTH = 24,
  parameter int MAX_RUN     = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // source frames
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // byte0, byte1, byte2, byte3
  input  logic                            s_axis_tuser,  // first_frame
  // destination frames
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // left_sample, right_sample
  output logic                            m_axis_tlast,  // run_last
  output logic [2:0]                      m_axis_tuser,  // is_stereo, run_truncated,
                                                         // conversion_done
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ps8r_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ps8r_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import ps8r_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // registers never stall
  assign cfg_ready_o = 1'b1;

  ps8r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ps8r_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .MAX_RUN     (MAX_RUN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_first_i  (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

endmodule

/* rtl/core/ps8r_checker.sv */
`include "pcm_to_s8_nearest_resampler_top_assert.svh"

module ps8r_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [2:0]  m_axis_tuser
);

  // one frame at a time: a taken frame closes the input
  `PS8R_ASSERT_NEXT(a_in_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // end of conversion only on the last frame of a run
  `PS8R_ASSERT_SAME(a_done_on_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast)
  // mono frames carry a zero right sample
  `PS8R_ASSERT_SAME(a_mono_right_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[15:8] == 8'h00)
  // stalled result holds
  `PS8R_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

endmodule

bind pcm_to_s8_nearest_resampler_top ps8r_checker u_ps8r_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

/* test/pcm_to_s8_nearest_resampler_top_tb.sv */
module pcm_to_s8_nearest_resampler_top_tb;
  import ps8r_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int COUNT_WIDTH    = 24;
  localparam int MAX_RUN        = 64;
  localparam int SETTLE_CYCLES  = 200;      // worst single-frame latency with margin
  localparam int RX_HOLD_CYCLES = 500;      // long output back-pressure window
  localparam int RANDOM_ITEMS   = 200;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam longint unsigned COUNT_MAX = 64'hFF_FFFF;

  // One destination frame as it leaves m_axis.
  typedef struct packed {
    logic [7:0] left_sample;
    logic [7:0] right_sample;
    logic       is_stereo;
    logic       run_last;
    logic       run_truncated;
    logic       conversion_done;
  } s8_frame_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_e;

  // Resampler timeline mirror plus the queue of frames it still owes.
  class s8_frame_scoreboard;
    fmt_e       fmt;
    logic [1:0] chans;
    bit         mix;
    bit [23:0]  src_cnt;
    bit [23:0]  dst_cnt;
    bit [24:0]  err_acc;
    bit [23:0]  emitted;
    bit [23:0]  skip_left;
    s8_frame_t  owed_q[$];
    int         fails;

    function new();
      fmt       = FMT_U8;
      chans     = 2'd1;
      mix       = 1'b0;
      src_cnt   = 24'd1;
      dst_cnt   = 24'd1;
      err_acc   = '0;
      emitted   = '0;
      skip_left = '0;
      fails     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FORMAT:   fmt = fmt_e'(val[1:0]);
        CFG_CHANNELS: chans = val[1:0];
        CFG_MIX:      mix = val[0];
        CFG_SRC:      src_cnt = val[23:0];
        CFG_DEST:     dst_cnt = val[23:0];
        default: ;
      endcase
    endfunction

    // top byte of one channel as a signed 8-bit value
    function logic [7:0] chan_top(bit [31:0] bytes, int ch);
      int         off;
      int         size;
      int         idx;
      logic [7:0] v;
      off  = (fmt == FMT_S16_LE) ? 1 : 0;
      size = (fmt == FMT_S16_LE || fmt == FMT_S16_BE) ? 2 : 1;
      idx  = (off + ch * size) % 4;
      v    = bytes[8*idx +: 8];
      if (fmt == FMT_U8) v = v ^ SIGN_FLIP;
      return v;
    endfunction

    // Accepted source frame: advance the timeline and queue the frames it owes.
    // Returns -1 when the frame is simply ignored (conversion finished).
    function int note_frame(bit first, bit [31:0] bytes);
      longint unsigned remaining, run_len, actual, shown, acc, k;
      logic [7:0] a, c;
      int         avg;
      bit         trunc, done;
      s8_frame_t  f;
      if (first) begin
        err_acc   = '0;
        emitted   = '0;
        skip_left = '0;
      end
      if (skip_left != 0) begin
        skip_left = skip_left - 1'b1;
        return 0;
      end
      if (emitted >= dst_cnt) return -1;
      remaining = dst_cnt - emitted;

      acc = err_acc;
      if (acc + src_cnt >= dst_cnt) run_len = 1;
      else if (src_cnt == 0) run_len = remaining;        // endless run
      else run_len = (dst_cnt - acc + src_cnt - 1) / src_cnt;

      actual  = (run_len < remaining) ? run_len : remaining;
      shown   = (actual < MAX_RUN) ? actual : MAX_RUN;
      trunc   = actual > MAX_RUN;
      emitted = emitted + actual[23:0];
      acc     = acc + actual * src_cnt;
      if (dst_cnt != 0 && acc >= dst_cnt) begin
        k         = acc / dst_cnt;
        acc       = acc - k * dst_cnt;
        k         = k - 1;
        skip_left = (k > COUNT_MAX) ? '1 : k[23:0];
      end
      err_acc = acc[24:0];
      done    = emitted >= dst_cnt;

      a = chan_top(bytes, 0);
      c = chan_top(bytes, 1);
      f = '0;
      if (chans == CHAN_STEREO && mix) begin
        avg = (int'($signed(a)) + int'($signed(c)) + 256) / 2 - 128;  // floor average
        f.left_sample = avg[7:0];
      end else if (chans == CHAN_STEREO) begin
        f.left_sample  = a;
        f.right_sample = c;
        f.is_stereo    = 1'b1;
      end else begin
        f.left_sample = a;
      end
      f.run_truncated = trunc;
      for (int i = 0; i < int'(shown); i++) begin
        f.run_last        = (i + 1 == int'(shown));
        f.conversion_done = f.run_last && done;
        owed_q.push_back(f);
      end
      return int'(shown);
    endfunction

    function void check_frame(s8_frame_t got);
      s8_frame_t want;
      if (owed_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected frame L=%0d R=%0d stereo=%0b last=%0b trunc=%0b done=%0b",
                   $signed(got.left_sample), $signed(got.right_sample), got.is_stereo,
                   got.run_last, got.run_truncated, got.conversion_done);
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) begin
          $display("frame mismatch: want L=%0d R=%0d st=%0b last=%0b tr=%0b dn=%0b",
                   $signed(want.left_sample), $signed(want.right_sample), want.is_stereo,
                   want.run_last, want.run_truncated, want.conversion_done);
          $display("                got  L=%0d R=%0d st=%0b last=%0b tr=%0b dn=%0b",
                   $signed(got.left_sample), $signed(got.right_sample), got.is_stereo,
                   got.run_last, got.run_truncated, got.conversion_done);
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic [2:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  s8_frame_scoreboard frame_sb = new();

  int          burst_left   = 0;
  int          active_items = 0;
  bit          hold_req     = 1'b0;
  int          rx_hold_left = 0;
  rx_pattern_e rx_pattern   = RX_OPEN;
  int          rx_pattern_left = 0;
  int          rx_tick      = 0;
  s8_frame_t   rx_frame;

  pcm_to_s8_nearest_resampler_top #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .MAX_RUN    (MAX_RUN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Output side: check every transfer, then pick the next tready.
  // A hold request from the stimulus forces a long stall; otherwise the
  // pattern switches between open, coin-flip, sparse and mostly-open stretches.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rx_frame.left_sample     = m_axis_tdata[7:0];
      rx_frame.right_sample    = m_axis_tdata[15:8];
      rx_frame.is_stereo       = m_axis_tuser[0];
      rx_frame.run_truncated   = m_axis_tuser[1];
      rx_frame.conversion_done = m_axis_tuser[2];
      rx_frame.run_last        = m_axis_tlast;
      frame_sb.check_frame(rx_frame);
    end
    if (hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      hold_req     = 1'b0;
    end
    if (rx_pattern_left == 0) begin
      rx_pattern      = rx_pattern_e'($urandom_range(0, 3));
      rx_pattern_left = $urandom_range(16, 200);
    end
    rx_pattern_left--;
    rx_tick++;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_pattern)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= (rx_tick % 4 == 0);
        default:   m_axis_tready <= (rx_tick % 7 != 3);
      endcase
    end
  end

  // Offer one source frame and hold it until the transfer. When paced, the
  // sender works in bursts and may drop tvalid for a random gap between them.
  task automatic send_frame(input bit first, input bit [31:0] bytes, input bit paced);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bytes;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    if (frame_sb.note_frame(first, bytes) >= 0) active_items++;
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
  endtask

  // Stop offering, wait for every owed frame, then let any skip or
  // ignore work that produces no output finish.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (frame_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input bit [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    frame_sb.set_reg(idx, val);
  endtask

  // Back-to-back register writes; valid drops only after the last one.
  task automatic write_config(input fmt_e fmt, input bit [1:0] chans, input bit mix,
                              input bit [23:0] src, input bit [23:0] dst);
    put_reg(CFG_FORMAT, CFG_DATA_W'(fmt));
    put_reg(CFG_CHANNELS, CFG_DATA_W'(chans));
    put_reg(CFG_MIX, CFG_DATA_W'(mix));
    put_reg(CFG_SRC, src);
    put_reg(CFG_DEST, dst);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    fmt_e      fmt;
    bit [1:0]  chans;
    bit        mix;
    bit [23:0] src;
    bit [23:0] dst;
    int        n_items;
    bit        fresh;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: U8 mono, one source frame to one destination frame.
    // Second frame lands after the conversion finished and must be ignored.
    send_frame(1'b1, 32'h0000_0000, 1'b1);
    send_frame(1'b0, 32'hFFFF_FFFF, 1'b1);
    send_frame(1'b1, 32'h0000_00FF, 1'b1);

    // S8 stereo upsample 2 -> 5, channel extremes
    wait_idle();
    write_config(FMT_S8, CHAN_STEREO, 1'b0, 24'd2, 24'd5);
    send_frame(1'b1, 32'h0000_7F80, 1'b1);
    send_frame(1'b0, 32'h1234_5601, 1'b1);
    send_frame(1'b0, $urandom, 1'b1);

    // S16 LE stereo mixed to mono, floor rounding on odd sums
    wait_idle();
    write_config(FMT_S16_LE, CHAN_STEREO, 1'b1, 24'd3, 24'd3);
    send_frame(1'b1, 32'h7F00_7F00, 1'b1);
    send_frame(1'b0, 32'h80FF_80FF, 1'b1);
    send_frame(1'b0, 32'h8000_7F00, 1'b1);

    // S16 BE mono downsample 5 -> 2, frames get skipped
    wait_idle();
    write_config(FMT_S16_BE, 2'd1, 1'b0, 24'd5, 24'd2);
    send_frame(1'b1, 32'h0000_FF80, 1'b1);
    send_frame(1'b0, $urandom, 1'b1);
    send_frame(1'b0, $urandom, 1'b1);
    send_frame(1'b0, $urandom, 1'b1);

    // Destination count cut below the accumulator mid-conversion:
    // one-frame run and a division-based skip.
    wait_idle();
    write_config(FMT_S8, 2'd1, 1'b0, 24'd7, 24'd10);
    send_frame(1'b1, $urandom, 1'b1);
    wait_idle();
    write_config(FMT_S8, 2'd1, 1'b0, 24'd7, 24'd3);
    send_frame(1'b0, $urandom, 1'b1);
    send_frame(1'b0, $urandom, 1'b1);

    // Longest run: one source frame covers the whole destination, cut at MAX_RUN
    wait_idle();
    write_config(FMT_U8, CHAN_STEREO, 1'b1, 24'd1, 24'hFF_FFFF);
    send_frame(1'b1, 32'h0000_FF00, 1'b1);
    send_frame(1'b0, $urandom, 1'b1);

    // Largest source count: one output, then a huge skip
    wait_idle();
    write_config(FMT_S16_BE, CHAN_STEREO, 1'b0, 24'hFF_FFFF, 24'd1);
    send_frame(1'b1, $urandom, 1'b1);
    send_frame(1'b0, $urandom, 1'b1);

    // Zero source count: endless run bounded by the destination count
    wait_idle();
    write_config(FMT_S8, 2'd1, 1'b0, 24'd0, 24'd5);
    send_frame(1'b1, $urandom, 1'b1);

    // Zero destination count: finished from the start
    wait_idle();
    write_config(FMT_S8, 2'd1, 1'b0, 24'd3, 24'd0);
    send_frame(1'b1, $urandom, 1'b1);

    // Back-pressure: output held off while frames keep coming, so the
    // block fills and stalls s_axis. wait_idle then drains everything.
    wait_idle();
    write_config(FMT_U8, CHAN_STEREO, 1'b0, 24'd4, 24'd40);
    hold_req = 1'b1;
    send_frame(1'b1, $urandom, 1'b0);
    repeat (7) send_frame(1'b0, $urandom, 1'b0);
    wait_idle();

    // Random conversions. Most start clean with first_frame; some carry the
    // old timeline into new register values, and a few frames restart at random.
    active_items = 0;
    while (active_items < RANDOM_ITEMS) begin
      fmt   = fmt_e'($urandom_range(0, 3));
      chans = 2'($urandom_range(1, 2));
      mix   = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0: begin
          src = 24'($urandom_range(1, 24'hFF_FFFF));
          dst = 24'($urandom_range(1, 48));
        end
        1: begin
          src = 24'($urandom_range(1, 8));
          dst = 24'($urandom_range(1000, 24'hFF_FFFF));
        end
        default: begin
          src = 24'($urandom_range(1, 24));
          dst = 24'($urandom_range(1, 48));
        end
      endcase
      n_items = (src < 40) ? src + $urandom_range(0, 3) : $urandom_range(4, 12);
      fresh   = ($urandom_range(0, 5) != 0);
      wait_idle();
      write_config(fmt, chans, mix, src, dst);
      for (int i = 0; i < n_items; i++)
        send_frame((i == 0 && fresh) || ($urandom_range(0, 19) == 0), $urandom, 1'b1);
    end

    wait_idle();
    if (frame_sb.fails == 0 && frame_sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ps8r_pkg.sv
rtl/core/ps8r_div.sv
rtl/core/ps8r_dp.sv
rtl/core/ps8r_ctrl.sv
rtl/core/pcm_to_s8_nearest_resampler_top.sv
rtl/core/ps8r_checker.sv
test/pcm_to_s8_nearest_resampler_top_tb.sv
